// ===== hdl/positional_list_insert_readout_macros.svh =====
// Assertion macros shared by the positional list insert and readout block.
`ifndef POSITIONAL_LIST_INSERT_READOUT_MACROS_SVH
`define POSITIONAL_LIST_INSERT_READOUT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PLI_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PLI_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/pli_pkg.sv =====
// Package with the types and constants of the positional list insert and readout block.
`timescale 1ns / 1ps
`default_nettype none

package pli_pkg;

   // List capacity and the widths that follow from it.
   localparam int CAPACITY = 16;
   localparam int LEN_W    = $clog2(CAPACITY + 1);
   localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int STEP_W   = LEN_W + 1;

   // Fixed widths of the item fields.
   localparam int POS_W  = 8;
   localparam int DATA_W = 32;

   // A value of all ones stops the block until reset.
   localparam logic signed [DATA_W-1:0] STOP_VALUE = -32'sd1;

   // Result kinds.
   typedef enum logic [1:0] {
      KIND_INVALID = 2'd0,
      KIND_FORWARD = 2'd1,
      KIND_REVERSE = 2'd2
   } kind_type;

   // One result handed from the sequencer to the output register.
   typedef struct packed {
      logic                     valid;
      kind_type                 kind;
      logic signed [DATA_W-1:0] element;
      logic                     last;
   } rsp_load_type;

   // Access to the list store.
   typedef struct packed {
      logic                     wr_en;
      logic [IDX_W-1:0]         wr_addr;
      logic signed [DATA_W-1:0] wr_data;
      logic [IDX_W-1:0]         rd_addr;
   } ram_req_type;

endpackage

`default_nettype wire

// ===== hdl/pli_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module pli_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  wire logic                  clock,
   input  wire logic                  wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]      wr_data,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== hdl/pli_outreg.sv =====
// Output register of the result channel.
`timescale 1ns / 1ps
`default_nettype none

module pli_outreg (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire pli_pkg::rsp_load_type      load,
   output logic                            out_free,
   output logic                            rsp_valid,
   input  wire logic                       rsp_stall,
   output logic [1:0]                      rsp_kind,
   output logic signed [pli_pkg::DATA_W-1:0] rsp_element,
   output logic                            rsp_last
);

   logic                              valid_ff;
   logic                              valid_in;
   logic [1:0]                        kind_ff;
   logic signed [pli_pkg::DATA_W-1:0] element_ff;
   logic                              last_ff;

   // The register can take a new item when it is empty or its item leaves now.
   assign out_free = !valid_ff || !rsp_stall;

   always_comb begin
      if (load.valid) begin
         valid_in = 1'b1;
      end else if (rsp_stall) begin
         valid_in = valid_ff;
      end else begin
         valid_in = 1'b0;
      end
   end

   // Valid flag under reset, payload without.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (load.valid) begin
         kind_ff    <= load.kind;
         element_ff <= load.element;
         last_ff    <= load.last;
      end
   end

   assign rsp_valid   = valid_ff;
   assign rsp_kind    = kind_ff;
   assign rsp_element = element_ff;
   assign rsp_last    = last_ff;

endmodule

`default_nettype wire

// ===== hdl/pli_seq.sv =====
// Sequencer that shifts, inserts and reads out the list through one address unit.
`timescale 1ns / 1ps
`default_nettype none

`include "positional_list_insert_readout_macros.svh"

module pli_seq (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [pli_pkg::POS_W-1:0]     req_position,
   input  wire logic signed [pli_pkg::DATA_W-1:0] req_value,
   input  wire logic                          out_free,
   output pli_pkg::rsp_load_type              load,
   output pli_pkg::ram_req_type               ram_req,
   input  wire logic signed [pli_pkg::DATA_W-1:0] ram_rdata
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_INVALID,
      S_SHIFT,
      S_INSERT,
      S_PRIME,
      S_EMIT
   } state_type;

   state_type                          state_ff, state_in;
   logic                               stopped_ff, stopped_in;
   logic [pli_pkg::LEN_W-1:0]          len_ff, len_in;
   logic [pli_pkg::IDX_W-1:0]          pos_ff, pos_in;
   logic signed [pli_pkg::DATA_W-1:0]  val_ff, val_in;
   logic [pli_pkg::IDX_W-1:0]          cur_ff, cur_in;
   logic [pli_pkg::IDX_W-1:0]          wa_ff, wa_in;
   logic                               pend_ff, pend_in;
   logic [pli_pkg::STEP_W-1:0]         step_ff, step_in;

   logic [pli_pkg::STEP_W-1:0]         len_ext;
   logic [pli_pkg::STEP_W-1:0]         step_last;
   logic [pli_pkg::STEP_W-1:0]         rev_off;
   logic [pli_pkg::IDX_W-1:0]          readout_addr;

   // Readout address: forward steps read the step index, reverse ones count back.
   assign len_ext   = pli_pkg::STEP_W'(len_ff);
   assign step_last = (len_ext << 1) - pli_pkg::STEP_W'(1);
   assign rev_off   = step_last - step_in;
   assign readout_addr = (step_in < len_ext) ? step_in[pli_pkg::IDX_W-1:0]
                                             : rev_off[pli_pkg::IDX_W-1:0];

   assign req_stall = (state_ff != S_IDLE);

   // Next state, store access and result hand-over.
   always_comb begin
      state_in   = state_ff;
      stopped_in = stopped_ff;
      len_in     = len_ff;
      pos_in     = pos_ff;
      val_in     = val_ff;
      cur_in     = cur_ff;
      wa_in      = wa_ff;
      pend_in    = pend_ff;
      step_in    = step_ff;

      ram_req.wr_en   = 1'b0;
      ram_req.wr_addr = pos_ff;
      ram_req.wr_data = val_ff;

      load.valid   = 1'b0;
      load.kind    = pli_pkg::KIND_INVALID;
      load.element = '0;
      load.last    = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid && !stopped_ff) begin
               if (req_value == pli_pkg::STOP_VALUE) begin
                  stopped_in = 1'b1;
               end else if ((req_position > pli_pkg::POS_W'(len_ff)) ||
                            (len_ff == pli_pkg::LEN_W'(pli_pkg::CAPACITY))) begin
                  state_in = S_INVALID;
               end else begin
                  pos_in   = req_position[pli_pkg::IDX_W-1:0];
                  val_in   = req_value;
                  cur_in   = len_ff[pli_pkg::IDX_W-1:0];
                  pend_in  = 1'b0;
                  state_in = S_SHIFT;
               end
            end
         end
         S_INVALID: begin
            if (out_free) begin
               load.valid = 1'b1;
               load.last  = 1'b1;
               state_in   = S_IDLE;
            end
         end
         S_SHIFT: begin
            // The entry read last cycle moves one place towards the tail.
            if (pend_ff) begin
               ram_req.wr_en   = 1'b1;
               ram_req.wr_addr = wa_ff;
               ram_req.wr_data = ram_rdata;
            end
            if (cur_ff != pos_ff) begin
               wa_in   = cur_ff;
               cur_in  = cur_ff - pli_pkg::IDX_W'(1);
               pend_in = 1'b1;
            end else begin
               pend_in  = 1'b0;
               state_in = S_INSERT;
            end
         end
         S_INSERT: begin
            ram_req.wr_en = 1'b1;
            len_in        = len_ff + pli_pkg::LEN_W'(1);
            step_in       = '0;
            state_in      = S_PRIME;
         end
         S_PRIME: begin
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (out_free) begin
               load.valid   = 1'b1;
               load.kind    = (step_ff < len_ext) ? pli_pkg::KIND_FORWARD
                                                  : pli_pkg::KIND_REVERSE;
               load.element = ram_rdata;
               load.last    = (step_ff == step_last);
               step_in      = step_ff + pli_pkg::STEP_W'(1);
               if (step_ff == step_last) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // The read port serves the shift while shifting and the readout otherwise.
      if (state_ff == S_SHIFT) begin
         ram_req.rd_addr = cur_ff - pli_pkg::IDX_W'(1);
      end else begin
         ram_req.rd_addr = readout_addr;
      end
   end

   // State and registered sequencer values.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         stopped_ff <= 1'b0;
         len_ff     <= '0;
         pend_ff    <= 1'b0;
         step_ff    <= '0;
      end else begin
         state_ff   <= state_in;
         stopped_ff <= stopped_in;
         len_ff     <= len_in;
         pend_ff    <= pend_in;
         step_ff    <= step_in;
      end
      pos_ff <= pos_in;
      val_ff <= val_in;
      cur_ff <= cur_in;
      wa_ff  <= wa_in;
   end

   // Checks on the sequencer.
   `PLI_ASSERT_SAME(a_len_cap, 1'b1, len_ff <= pli_pkg::LEN_W'(pli_pkg::CAPACITY), "list length above capacity")
   `PLI_ASSERT_NEXT(a_stop_holds, stopped_ff, stopped_ff, "stop flag cleared")
   `PLI_ASSERT_SAME(a_shift_above_pos, (state_ff == S_SHIFT) && pend_ff, wa_ff > pos_ff, "shift writes at or below the insert place")
   `PLI_ASSERT_NEXT(a_last_ends, load.valid && load.last, state_ff == S_IDLE, "item not finished after its final result")
   `PLI_ASSERT_NEXT(a_insert_grows, state_ff == S_INSERT, len_ff == $past(len_ff) + pli_pkg::LEN_W'(1), "insert did not grow the list")

endmodule

`default_nettype wire

// ===== hdl/positional_list_insert_readout.sv =====
// Top level of the positional list insert and readout block.
// Usage:
//   The request channel (req_valid, req_stall, req_position, req_value) brings one item:
//   an insert place and a signed value. The response channel (rsp_valid, rsp_stall,
//   rsp_kind, rsp_element, rsp_last) returns the results of that item; rsp_last marks
//   its final result. A value of minus one stops the block; that item and all later
//   ones are taken and give no result.
//   A place past the tail, or a full list, gives one invalid result and no change.
//   Otherwise the value is inserted and the whole list is read out head to tail,
//   then tail to head, one result per cycle while the receiver does not stall.
// Sequence:
//   An insert at place p shifts the entries from p to the tail one place, writes the
//   value and primes the first read, then gives the results; the next item is taken
//   only after the final result. An invalid item gives its one result and returns to
//   idle; a stop or ignored item needs only its acceptance. The single read port of
//   the list store sets the pace of both the shift and the readout.
// Reset empties the list and clears the stop flag. While the receiver stalls the
// pending result holds and the readout waits; req_stall stays high until the
// final result of an item has entered the output register.
`timescale 1ns / 1ps
`default_nettype none

module positional_list_insert_readout (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic [pli_pkg::POS_W-1:0]         req_position,
   input  wire logic signed [pli_pkg::DATA_W-1:0] req_value,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic [1:0]                             rsp_kind,
   output logic signed [pli_pkg::DATA_W-1:0]      rsp_element,
   output logic                                   rsp_last
);

   pli_pkg::rsp_load_type             load;
   pli_pkg::ram_req_type              ram_req;
   logic signed [pli_pkg::DATA_W-1:0] ram_rdata;
   logic                              out_free;

   // List store.
   pli_ram #(
      .WIDTH(pli_pkg::DATA_W),
      .DEPTH(pli_pkg::CAPACITY)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_req.wr_en),
      .wr_addr (ram_req.wr_addr),
      .wr_data (ram_req.wr_data),
      .rd_addr (ram_req.rd_addr),
      .rd_data (ram_rdata)
   );

   // Sequencer.
   pli_seq u_seq (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_position (req_position),
      .req_value    (req_value),
      .out_free     (out_free),
      .load         (load),
      .ram_req      (ram_req),
      .ram_rdata    (ram_rdata)
   );

   // Output register.
   pli_outreg u_outreg (
      .clock       (clock),
      .reset       (reset),
      .load        (load),
      .out_free    (out_free),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_kind    (rsp_kind),
      .rsp_element (rsp_element),
      .rsp_last    (rsp_last)
   );

endmodule

`default_nettype wire

// ===== tb/sv/tb_positional_list_insert_readout.sv =====
// Self-checking testbench for the positional list insert and readout block.
`timescale 1ns / 1ps

module tb_positional_list_insert_readout;
   import pli_pkg::*;

   // Cycles without any accepted item or result before the run is declared hung.
   localparam int QUIET_LIMIT = 3000;
   // Cycles to wait at the end so that any stray result shows up.
   localparam int DRAIN_CYCLES = 60;
   // Random items in the second phase.
   localparam int RANDOM_ITEMS = 160;
   // Mismatch lines printed before further ones are only counted.
   localparam int PRINT_LIMIT = 100;

   // How the expectation of a directed row is obtained.
   typedef enum logic [1:0] {
      ROW_PREDICT,
      ROW_INVALID,
      ROW_SOLO
   } row_check_type;

   typedef struct packed {
      logic [POS_W-1:0]         pos;
      logic signed [DATA_W-1:0] val;
      row_check_type            check;
   } directed_row_type;

   typedef struct packed {
      kind_type                 kind;
      logic signed [DATA_W-1:0] element;
      logic                     last;
   } readout_type;

   logic                     clock = 1'b0;
   logic                     reset;
   logic                     req_valid;
   logic                     req_stall;
   logic [POS_W-1:0]         req_position;
   logic signed [DATA_W-1:0] req_value;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic [1:0]               rsp_kind;
   logic signed [DATA_W-1:0] rsp_element;
   logic                     rsp_last;

   // Shadow copy of the list kept by the predictor.
   logic signed [DATA_W-1:0] list_vals [CAPACITY];
   int                       list_len = 0;
   bit                       halted = 1'b0;

   readout_type readout_due[$];
   readout_type fresh_readout[$];
   int          mismatches = 0;
   int          quiet_cycles = 0;
   bit          steady = 1'b0;

   // Directed items, starting from an empty list.
   directed_row_type plan [11] = '{
      '{8'd1,   32'sd5,           ROW_INVALID},
      '{8'd255, 32'sd0,           ROW_INVALID},
      '{8'd0,   32'sh7fffffff,    ROW_SOLO},
      '{8'd0,   32'sh80000000,    ROW_PREDICT},
      '{8'd2,   32'sd0,           ROW_PREDICT},
      '{8'd1,   -32'sd2,          ROW_PREDICT},
      '{8'd5,   32'sd9,           ROW_INVALID},
      '{8'd4,   32'sh5555aaaa,    ROW_PREDICT},
      '{8'd170, 32'shaaaa5555,    ROW_INVALID},
      '{8'd85,  32'sd1,           ROW_INVALID},
      '{8'd2,   32'sh0000ffff,    ROW_PREDICT}
   };

   positional_list_insert_readout dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_position (req_position),
      .req_value    (req_value),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_kind     (rsp_kind),
      .rsp_element  (rsp_element),
      .rsp_last     (rsp_last)
   );

   always #10 clock = ~clock;

   // Prints one mismatch line and counts it.
   task automatic report_mismatch(input string what);
      if (mismatches < PRINT_LIMIT) begin
         $display("%0t ns: mismatch: %s", $time, what);
      end
      mismatches++;
   endtask

   // Applies one item to the shadow list and appends the results it causes.
   function automatic void predict_insert(input logic [POS_W-1:0] pos,
                                          input logic signed [DATA_W-1:0] val);
      int i;
      if (halted) begin
         return;
      end
      if (val == STOP_VALUE) begin
         halted = 1'b1;
         return;
      end
      if (pos > list_len || list_len >= CAPACITY) begin
         fresh_readout.push_back('{KIND_INVALID, '0, 1'b1});
         return;
      end
      for (i = list_len; i > pos; i--) begin
         list_vals[i] = list_vals[i-1];
      end
      list_vals[pos] = val;
      list_len++;
      for (i = 0; i < list_len; i++) begin
         fresh_readout.push_back('{KIND_FORWARD, list_vals[i], 1'b0});
      end
      for (i = list_len; i > 0; i--) begin
         fresh_readout.push_back('{KIND_REVERSE, list_vals[i-1], i == 1});
      end
   endfunction

   // Offers one item from a falling edge and books its expected results once taken.
   task automatic send_item(input logic [POS_W-1:0] pos, input logic signed [DATA_W-1:0] val,
                            input row_check_type check);
      while (!steady && $urandom_range(0, 99) < 37) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid    <= 1'b1;
      req_position <= pos;
      req_value    <= val;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      fresh_readout.delete();
      predict_insert(pos, val);
      case (check)
         ROW_INVALID: begin
            readout_due.push_back('{KIND_INVALID, '0, 1'b1});
         end
         ROW_SOLO: begin
            readout_due.push_back('{KIND_FORWARD, val, 1'b0});
            readout_due.push_back('{KIND_REVERSE, val, 1'b1});
         end
         default: begin
            foreach (fresh_readout[k]) readout_due.push_back(fresh_readout[k]);
         end
      endcase
      @(negedge clock);
   endtask

   // Insert place: mostly inside the list, sometimes past the tail.
   function automatic logic [POS_W-1:0] random_position();
      int pick;
      pick = $urandom_range(0, 99);
      if (list_len >= CAPACITY) begin
         return (pick < 60) ? POS_W'($urandom_range(0, CAPACITY))
                            : POS_W'($urandom_range(CAPACITY + 1, 255));
      end
      return (pick < 60) ? POS_W'($urandom_range(0, list_len))
                         : POS_W'($urandom_range(list_len + 1, 255));
   endfunction

   // Value with a bias towards the extremes; the stop value is kept out.
   function automatic logic signed [DATA_W-1:0] random_value();
      int                       pick;
      logic signed [DATA_W-1:0] v;
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
         v = 32'sh7fffffff;
      end else if (pick < 16) begin
         v = 32'sh80000000;
      end else if (pick < 22) begin
         v = '0;
      end else begin
         v = $urandom;
      end
      if (v == STOP_VALUE) begin
         v = -32'sd2;
      end
      return v;
   endfunction

   // The receiver stalls at random, except during the steady stretch.
   always @(negedge clock) begin
      rsp_stall <= steady ? 1'b0 : ($urandom_range(0, 99) < 37);
   end

   // Result checking and the hang watchdog.
   always @(posedge clock) begin : check_results
      readout_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (readout_due.size() == 0) begin
            report_mismatch($sformatf("unexpected result kind %0d element %0d",
                                      rsp_kind, rsp_element));
         end else begin
            want = readout_due.pop_front();
            if (rsp_kind !== want.kind)
               report_mismatch($sformatf("kind %0d, expected %0d", rsp_kind, want.kind));
            if (rsp_element !== want.element)
               report_mismatch($sformatf("element %0d, expected %0d",
                                         rsp_element, want.element));
            if (rsp_last !== want.last)
               report_mismatch($sformatf("last %0b, expected %0b", rsp_last, want.last));
         end
      end
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("FAILED: results differ");
         $finish;
      end
   end

   initial begin
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_position = '0;
      req_value    = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed items: invalid places, extremes and inserts at head, middle and tail.
      for (int r = 0; r < $size(plan); r++) begin
         send_item(plan[r].pos, plan[r].val, plan[r].check);
      end

      // Hold off until the block has handed over every result so far.
      req_valid <= 1'b0;
      @(negedge clock);
      while (readout_due.size() != 0) begin
         @(negedge clock);
      end

      // Random items fill the list and then keep hitting the full list.
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         steady = (n >= 60 && n < 100);
         send_item(random_position(), random_value(), ROW_PREDICT);
      end
      steady = 1'b0;

      // The stop value, then items that must be ignored.
      send_item(random_position(), STOP_VALUE, ROW_PREDICT);
      send_item(8'd0, 32'sd7, ROW_PREDICT);
      send_item(random_position(), random_value(), ROW_PREDICT);

      req_valid <= 1'b0;
      @(negedge clock);
      while (readout_due.size() != 0) begin
         @(negedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatches == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/pli_pkg.sv
hdl/pli_ram.sv
hdl/pli_outreg.sv
hdl/pli_seq.sv
hdl/positional_list_insert_readout.sv
tb/sv/tb_positional_list_insert_readout.sv
